// File: src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the cell locator checks.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/igcl_pkg.sv
// ============================================================================
// igcl_pkg
// Types and constants shared by the irregular grid cell locator modules.
// ============================================================================
`timescale 1ns / 1ps

package igcl_pkg;

    localparam int COORD_W = 32;
    localparam int PARTS_W = 7;
    localparam int SQ_W    = 2 * PARTS_W;

    localparam logic [COORD_W-1:0] ONE_FIXED = 32'h8000_0000;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [2:0] {
        OP_LOAD_X = 3'd0,
        OP_LOAD_Y = 3'd1,
        OP_PLACE  = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_RECT   = 3'd5
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               status;
        logic [7:0]         index;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_hi;
        logic [PARTS_W-1:0] parts;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] key_x;
        logic [COORD_W-1:0] key_y;
        logic [PARTS_W-1:0] parts;
        logic               wr_en;
        logic               wr_y;
        logic [7:0]         wr_addr;
        logic [COORD_W-1:0] wr_data;
    } t_loc_req;

    typedef struct packed {
        logic               done;
        logic [PARTS_W-1:0] col;
        logic [PARTS_W-1:0] row;
    } t_loc_rsp;

    typedef struct packed {
        logic [3:0]  col_lo;
        logic [3:0]  row_lo;
        logic [3:0]  col_hi;
        logic [3:0]  row_hi;
        logic [7:0]  cell_id;
        logic [19:0] slot;
        logic [19:0] count;
        logic        status;
    } t_result;

endpackage

// File: src/irregular_grid_cell_locator_unit.sv
// ============================================================================
// irregular_grid_cell_locator_unit
// Two-dimensional bucketing on a grid with irregular split tables: loads
// splits, places points with saturating per-cell counts, reads and clears
// counts, and locates the corner cells of a query rectangle.
// ============================================================================
//  channel   direction  handshake                 word
//  command   in         start high, busy low      i_op, i_index, i_coord_*
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (cells per axis)
//  result    out        o_strobe, one cycle       o_col_*, o_row_*, o_cell_id,
//                                                 o_slot, o_count, o_status
//
// The bisection unit searches both axes at once over the split tables, P cells
// per axis. A place locates one corner and then reads and writes the cell
// count; a rectangle locates both corners; a clear writes every cell of the
// count memory in turn through its single write port.
// After reset the count memory is swept with busy high. A two-word queue holds
// commands while the back end works; busy rises when it is full. The receiver
// cannot stall results.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irregular_grid_cell_locator_unit import igcl_pkg::*; #(
    parameter int MAX_PARTS  = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_index,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_x_hi,
    input  logic [31:0] i_coord_y_hi,
    output logic        o_strobe,
    output logic [3:0]  o_col_lo,
    output logic [3:0]  o_row_lo,
    output logic [3:0]  o_col_hi,
    output logic [3:0]  o_row_hi,
    output logic [7:0]  o_cell_id,
    output logic [19:0] o_slot,
    output logic [19:0] o_count,
    output logic        o_status
);

    logic     w_push;
    t_cmd     w_cmd;
    t_cmd     w_head;
    logic     w_pop;
    logic     w_empty;
    logic     w_full;
    logic     w_init;
    t_loc_req w_loc_req;
    t_loc_rsp w_loc_rsp;
    t_result  w_res;

    assign busy = w_full || w_init;

    igcl_front #(
        .MAX_PARTS (MAX_PARTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_x_hi (i_coord_x_hi),
        .i_coord_y_hi (i_coord_y_hi),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    igcl_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    igcl_locate #(
        .MAX_PARTS (MAX_PARTS)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_loc_req),
        .o_rsp   (w_loc_rsp)
    );

    igcl_back #(
        .MAX_PARTS  (MAX_PARTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_loc_req (w_loc_req),
        .i_loc_rsp (w_loc_rsp),
        .o_init    (w_init),
        .o_strobe  (o_strobe),
        .o_res     (w_res)
    );

    assign o_col_lo  = w_res.col_lo;
    assign o_row_lo  = w_res.row_lo;
    assign o_col_hi  = w_res.col_hi;
    assign o_row_hi  = w_res.row_hi;
    assign o_cell_id = w_res.cell_id;
    assign o_slot    = w_res.slot;
    assign o_count   = w_res.count;
    assign o_status  = w_res.status;

    `ASSERT_IMP(a_range_word_clean, i_clk, i_rst_n, o_strobe && o_status, (o_count == 20'd0) && (o_slot == 20'd0) && (o_cell_id == 8'd0), "Out-of-range word carries data.")
    `ASSERT_IMP(a_slot_count_step, i_clk, i_rst_n, o_strobe && (o_slot != 20'd0), (o_count == o_slot) || (o_count == o_slot + 20'd1), "Placed count does not follow its slot.")
    `ASSERT_NXT(a_no_word_in_sweep, i_clk, i_rst_n, w_init, !o_strobe, "Result word during post-reset sweep.")

endmodule

// File: src/igcl_front.sv
// ============================================================================
// igcl_front
// Holds the grid size register, accepts command words and classifies them.
// ============================================================================
`timescale 1ns / 1ps

module igcl_front import igcl_pkg::*; #(
    parameter int MAX_PARTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_index,
    input  logic [COORD_W-1:0] i_coord_x,
    input  logic [COORD_W-1:0] i_coord_y,
    input  logic [COORD_W-1:0] i_coord_x_hi,
    input  logic [COORD_W-1:0] i_coord_y_hi,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [4:0]         r_parts;
    logic [PARTS_W-1:0] w_parts;
    logic [SQ_W-1:0]    w_cells;
    t_op                w_op;
    logic               w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts <= 5'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_parts <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_parts < 5'd2) begin
            w_parts = PARTS_W'(2);
        end else if (PARTS_W'(r_parts) > PARTS_W'(MAX_PARTS)) begin
            w_parts = PARTS_W'(MAX_PARTS);
        end else begin
            w_parts = PARTS_W'(r_parts);
        end
    end

    assign w_cells = SQ_W'(w_parts) * SQ_W'(w_parts);
    assign w_op    = t_op'(i_op);

    always_comb begin
        unique case (w_op) inside
            OP_LOAD_X, OP_LOAD_Y: begin
                w_status = (32'(i_index) >= 32'(MAX_PARTS - 1)) ? STATUS_RANGE : STATUS_OK;
            end
            OP_READ: begin
                w_status = (SQ_W'(i_index) >= w_cells) ? STATUS_RANGE : STATUS_OK;
            end
            default: begin
                w_status = STATUS_OK;
            end
        endcase
    end

    assign o_push       = i_start && !i_busy;
    assign o_cmd.op     = w_op;
    assign o_cmd.status = w_status;
    assign o_cmd.index  = i_index;
    assign o_cmd.x_lo   = i_coord_x;
    assign o_cmd.y_lo   = i_coord_y;
    assign o_cmd.x_hi   = (i_coord_x_hi > ONE_FIXED) ? ONE_FIXED : i_coord_x_hi;
    assign o_cmd.y_hi   = (i_coord_y_hi > ONE_FIXED) ? ONE_FIXED : i_coord_y_hi;
    assign o_cmd.parts  = w_parts;

endmodule

// File: src/igcl_cmd_fifo.sv
// ============================================================================
// igcl_cmd_fifo
// Two-entry command queue between the front end and the execution back end.
// ============================================================================
`timescale 1ns / 1ps

module igcl_cmd_fifo import igcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// File: src/igcl_locate.sv
// ============================================================================
// igcl_locate
// Split tables and a two-lane bisection unit, one probe per lane per cycle.
// ============================================================================
`timescale 1ns / 1ps

module igcl_locate import igcl_pkg::*; #(
    parameter int MAX_PARTS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_loc_req i_req,
    output t_loc_rsp o_rsp
);

    localparam int SPLIT_DEPTH = MAX_PARTS - 1;
    localparam int W           = $clog2(MAX_PARTS);
    localparam int SI_W        = (SPLIT_DEPTH > 1) ? $clog2(SPLIT_DEPTH) : 1;

    logic [COORD_W-1:0] r_tab [2][SPLIT_DEPTH];
    logic               r_run;
    logic [W-1:0]       r_low [2];
    logic [W-1:0]       r_hp1 [2];
    logic [W-1:0]       r_ans [2];
    logic [COORD_W-1:0] r_key [2];
    logic [W-1:0]       r_n;

    logic [W-1:0] w_n;
    logic [W:0]   w_sum   [2];
    logic [W-1:0] w_mid   [2];
    logic         w_act   [2];
    logic         w_below [2];
    logic         w_done;

    assign w_n = W'(i_req.parts - PARTS_W'(1));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_act[l]   = r_low[l] < r_hp1[l];
            w_sum[l]   = (W+1)'(r_low[l]) + (W+1)'(r_hp1[l]) - (W+1)'(1);
            w_mid[l]   = w_sum[l][W:1];
            w_below[l] = r_tab[l][w_mid[l][SI_W-1:0]] < r_key[l];
        end
    end

    assign w_done = r_run && !w_act[0] && !w_act[1];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_tab[i_req.wr_y][i_req.wr_addr[SI_W-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_req.start) begin
            r_run <= 1'b1;
        end else if (w_done) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            for (int l = 0; l < 2; l++) begin
                r_low[l] <= '0;
                r_hp1[l] <= w_n;
                r_ans[l] <= w_n - W'(1);
            end
            r_key[0] <= i_req.key_x;
            r_key[1] <= i_req.key_y;
            r_n      <= w_n;
        end else if (r_run) begin
            for (int l = 0; l < 2; l++) begin
                if (w_act[l]) begin
                    if (w_below[l]) begin
                        r_low[l] <= w_mid[l] + W'(1);
                    end else begin
                        r_ans[l] <= w_mid[l];
                        r_hp1[l] <= w_mid[l];
                    end
                end
            end
        end
    end

    assign o_rsp.done = w_done;
    assign o_rsp.col  = PARTS_W'((r_low[0] == r_n) ? r_n : r_ans[0]);
    assign o_rsp.row  = PARTS_W'((r_low[1] == r_n) ? r_n : r_ans[1]);

endmodule

// File: src/igcl_back.sv
// ============================================================================
// igcl_back
// Executes queued commands: split loads, searches, cell count updates, reads
// and clears, and drives the registered result word.
// ============================================================================
`timescale 1ns / 1ps

module igcl_back import igcl_pkg::*; #(
    parameter int MAX_PARTS  = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_cmd     i_head,
    output logic     o_pop,
    output t_loc_req o_loc_req,
    input  t_loc_rsp i_loc_rsp,
    output logic     o_init,
    output logic     o_strobe,
    output t_result  o_res
);

    localparam int CELL_DEPTH = MAX_PARTS * MAX_PARTS;
    localparam int CA_W       = $clog2(CELL_DEPTH);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOC_LO,
        S_LOC_HI,
        S_PRD,
        S_PWR,
        S_RDC,
        S_CLR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   n_strobe;
    t_result r_res;
    t_result n_res;
    logic [CA_W-1:0] r_sweep;
    logic [CA_W-1:0] n_sweep;

    t_cmd               r_cmd;
    logic [PARTS_W-1:0] r_col_lo;
    logic [PARTS_W-1:0] r_row_lo;
    logic [CA_W-1:0]    r_cell;
    logic               w_cap_lo;
    logic [SQ_W-1:0]    w_cell_full;

    logic [COUNT_BITS-1:0] r_cnt_mem [CELL_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  w_we;
    logic [CA_W-1:0]       w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [CA_W-1:0]       w_raddr;
    logic [COUNT_BITS-1:0] w_inc;

    assign w_inc = (r_rd_data == '1) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
    assign w_cell_full = SQ_W'(i_loc_rsp.row) * SQ_W'(r_cmd.parts) + SQ_W'(i_loc_rsp.col);

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_sweep  = r_sweep;
        o_pop    = 1'b0;
        w_cap_lo = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_cell;
        w_wdata  = w_inc;
        w_raddr  = r_cell;

        o_loc_req.start   = 1'b0;
        o_loc_req.key_x   = r_cmd.x_hi;
        o_loc_req.key_y   = r_cmd.y_hi;
        o_loc_req.parts   = r_cmd.parts;
        o_loc_req.wr_en   = 1'b0;
        o_loc_req.wr_y    = (i_head.op == OP_LOAD_Y);
        o_loc_req.wr_addr = i_head.index;
        o_loc_req.wr_data = i_head.x_lo;

        unique case (r_state)
            S_INIT, S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = '0;
                if (r_sweep == CA_W'(CELL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                    if (r_state == S_CLR) begin
                        n_strobe = 1'b1;
                        n_res    = '0;
                    end
                end else begin
                    n_sweep = r_sweep + CA_W'(1);
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.op) inside
                        OP_LOAD_X, OP_LOAD_Y: begin
                            o_loc_req.wr_en = (i_head.status == STATUS_OK);
                            n_strobe        = 1'b1;
                            n_res           = '0;
                            n_res.status    = i_head.status;
                        end
                        OP_PLACE, OP_RECT: begin
                            o_loc_req.start = 1'b1;
                            o_loc_req.key_x = i_head.x_lo;
                            o_loc_req.key_y = i_head.y_lo;
                            o_loc_req.parts = i_head.parts;
                            n_state         = S_LOC_LO;
                        end
                        OP_READ: begin
                            if (i_head.status == STATUS_RANGE) begin
                                n_strobe     = 1'b1;
                                n_res        = '0;
                                n_res.status = STATUS_RANGE;
                            end else begin
                                w_raddr = CA_W'(i_head.index);
                                n_state = S_RDC;
                            end
                        end
                        OP_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res    = '0;
                        end
                    endcase
                end
            end
            S_LOC_LO: begin
                if (i_loc_rsp.done) begin
                    w_cap_lo = 1'b1;
                    if (r_cmd.op == OP_PLACE) begin
                        n_state = S_PRD;
                    end else begin
                        o_loc_req.start = 1'b1;
                        n_state         = S_LOC_HI;
                    end
                end
            end
            S_LOC_HI: begin
                if (i_loc_rsp.done) begin
                    n_strobe      = 1'b1;
                    n_res         = '0;
                    n_res.col_lo  = 4'(r_col_lo);
                    n_res.row_lo  = 4'(r_row_lo);
                    n_res.col_hi  = 4'(i_loc_rsp.col);
                    n_res.row_hi  = 4'(i_loc_rsp.row);
                    n_res.cell_id = 8'(r_cell);
                    n_state       = S_IDLE;
                end
            end
            S_PRD: begin
                n_state = S_PWR;
            end
            S_PWR: begin
                w_we          = 1'b1;
                n_strobe      = 1'b1;
                n_res         = '0;
                n_res.col_lo  = 4'(r_col_lo);
                n_res.row_lo  = 4'(r_row_lo);
                n_res.cell_id = 8'(r_cell);
                n_res.slot    = 20'(r_rd_data);
                n_res.count   = 20'(w_inc);
                n_state       = S_IDLE;
            end
            S_RDC: begin
                n_strobe    = 1'b1;
                n_res       = '0;
                n_res.count = 20'(r_rd_data);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_strobe <= 1'b0;
            r_sweep  <= '0;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_sweep  <= n_sweep;
            r_res    <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (w_cap_lo) begin
            r_col_lo <= i_loc_rsp.col;
            r_row_lo <= i_loc_rsp.row;
            r_cell   <= CA_W'(w_cell_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cnt_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_cnt_mem[w_raddr];
    end

    assign o_init   = (r_state == S_INIT);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the irregular grid cell locator. It loads split
// tables, places points, reads and clears cell counts and locates rectangles
// under several grid sizes and sender idle patterns. An in-bench model of the
// grid predicts every result word, and a monitor checks them in order.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import igcl_pkg::*;

    localparam logic [2:0]  OP_SPARE_6  = 3'd6;
    localparam logic [2:0]  OP_SPARE_7  = 3'd7;
    localparam int          SPLIT_SLOTS = 15;
    localparam int          GRID_CELLS  = 256;
    localparam int          GRID_MAX    = 16;
    localparam logic [19:0] TALLY_MAX   = 20'hF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;
    logic [2:0]  i_op;
    logic [7:0]  i_index;
    logic [31:0] i_coord_x;
    logic [31:0] i_coord_y;
    logic [31:0] i_coord_x_hi;
    logic [31:0] i_coord_y_hi;
    logic        o_strobe;
    logic [3:0]  o_col_lo;
    logic [3:0]  o_row_lo;
    logic [3:0]  o_col_hi;
    logic [3:0]  o_row_hi;
    logic [7:0]  o_cell_id;
    logic [19:0] o_slot;
    logic [19:0] o_count;
    logic        o_status;

    logic [31:0] x_bounds [SPLIT_SLOTS];
    logic [31:0] y_bounds [SPLIT_SLOTS];
    logic [19:0] cell_tally [GRID_CELLS];
    logic [4:0]  grid_size_reg;

    t_result pending_results [$];
    t_result seen_word;
    t_result due_word;

    int sender_idle_pct;
    int n_sent;
    int n_checked;
    int n_mismatch;
    int n_placed;
    int n_rects;
    int n_sizes;

    irregular_grid_cell_locator_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_x_hi (i_coord_x_hi),
        .i_coord_y_hi (i_coord_y_hi),
        .o_strobe     (o_strobe),
        .o_col_lo     (o_col_lo),
        .o_row_lo     (o_row_lo),
        .o_col_hi     (o_col_hi),
        .o_row_hi     (o_row_hi),
        .o_cell_id    (o_cell_id),
        .o_slot       (o_slot),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic int grid_parts();
        int p;
        p = grid_size_reg;
        if (p < 2) p = 2;
        if (p > GRID_MAX) p = GRID_MAX;
        return p;
    endfunction

    // Bisection for the first split at or above the key; the last cell if none.
    function automatic logic [3:0] find_bin(input bit y_axis, input logic [31:0] key);
        int n;
        int lo;
        int hi;
        int ans;
        int mid;
        logic [31:0] probe;
        n   = grid_parts() - 1;
        lo  = 0;
        hi  = n - 1;
        ans = n - 1;
        while (lo <= hi) begin
            mid   = (lo + hi) / 2;
            probe = y_axis ? y_bounds[mid] : x_bounds[mid];
            if (probe < key) begin
                lo = mid + 1;
            end else begin
                ans = mid;
                hi  = mid - 1;
            end
        end
        if (lo > n - 1) return 4'(n);
        return 4'(ans);
    endfunction

    function automatic t_result predict_grid_result(input logic [2:0] op,
                                                    input logic [7:0] idx,
                                                    input logic [31:0] cx,
                                                    input logic [31:0] cy,
                                                    input logic [31:0] cxh,
                                                    input logic [31:0] cyh);
        t_result r;
        int p;
        int cell_idx;
        r    = '0;
        p    = grid_parts();
        case (op)
            OP_LOAD_X, OP_LOAD_Y: begin
                if (idx >= SPLIT_SLOTS) begin
                    r.status = STATUS_RANGE;
                end else if (op == OP_LOAD_X) begin
                    x_bounds[idx] = cx;
                end else begin
                    y_bounds[idx] = cx;
                end
            end
            OP_PLACE: begin
                r.col_lo  = find_bin(1'b0, cx);
                r.row_lo  = find_bin(1'b1, cy);
                cell_idx  = r.row_lo * p + r.col_lo;
                r.cell_id = 8'(cell_idx);
                r.slot    = cell_tally[cell_idx];
                if (cell_tally[cell_idx] < TALLY_MAX) begin
                    cell_tally[cell_idx] = cell_tally[cell_idx] + 1;
                end
                r.count   = cell_tally[cell_idx];
                n_placed++;
            end
            OP_READ: begin
                if (idx >= p * p) r.status = STATUS_RANGE;
                else r.count = cell_tally[idx];
            end
            OP_CLEAR: begin
                foreach (cell_tally[i]) cell_tally[i] = '0;
            end
            OP_RECT: begin
                if (cxh > ONE_FIXED) cxh = ONE_FIXED;
                if (cyh > ONE_FIXED) cyh = ONE_FIXED;
                r.col_lo  = find_bin(1'b0, cx);
                r.row_lo  = find_bin(1'b1, cy);
                r.col_hi  = find_bin(1'b0, cxh);
                r.row_hi  = find_bin(1'b1, cyh);
                r.cell_id = 8'(r.row_lo * p + r.col_lo);
                n_rects++;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [7:0] idx,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cxh, input logic [31:0] cyh);
        t_result want;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_op         = op;
        i_index      = idx;
        i_coord_x    = cx;
        i_coord_y    = cy;
        i_coord_x_hi = cxh;
        i_coord_y_hi = cyh;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = predict_grid_result(op, idx, cx, cy, cxh, cyh);
        pending_results = {pending_results, want};
        n_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_grid_size(input logic [4:0] parts);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = parts;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        grid_size_reg = parts;
        n_sizes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] even_split(input int i);
        return 32'((i + 1) * 32'h0800_0000 - $urandom_range(0, 32'h03FF_FFFF));
    endfunction

    function automatic logic [31:0] pick_coord(input bit y_axis);
        logic [31:0] b;
        b = y_axis ? y_bounds[$urandom_range(0, grid_parts() - 2)]
                   : x_bounds[$urandom_range(0, grid_parts() - 2)];
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            4:       return b;
            5:       return b + 32'(int'($urandom_range(0, 2)) - 1);
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    task automatic test_split_tables();
        for (int i = 0; i < SPLIT_SLOTS; i++) begin
            send_word(OP_LOAD_X, 8'(i), even_split(i), $urandom, $urandom, $urandom);
            send_word(OP_LOAD_Y, 8'(i), even_split(i), $urandom, $urandom, $urandom);
        end
        send_word(OP_LOAD_X, 8'd15, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_word(OP_LOAD_Y, 8'd255, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_place_corners();
        send_word(OP_PLACE, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, x_bounds[1], y_bounds[0], 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, x_bounds[2] + 1, y_bounds[2], 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, x_bounds[0] + 1, y_bounds[1] - 1, 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, ONE_FIXED, ONE_FIXED, 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_count_reads();
        send_word(OP_READ, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_READ, 8'd15, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_READ, 8'd16, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_READ, 8'd255, 32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_rectangles();
        send_word(OP_RECT, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_RECT, 8'd0, x_bounds[0], y_bounds[1], ONE_FIXED, ONE_FIXED);
        send_word(OP_RECT, 8'd0, ONE_FIXED, ONE_FIXED, 32'h8000_0001, 32'h0);
        send_word(OP_RECT, 8'd0, 32'hFFFF_FFFF, 32'h1234_5678, x_bounds[2], y_bounds[2] + 1);
    endtask

    task automatic test_clear_and_spare_ops();
        send_word(OP_CLEAR, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_READ, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_SPARE_6, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_SPARE_7, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_PLACE, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic random_command();
        int pick;
        int p;
        logic [7:0] idx;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        p    = grid_parts();
        if (pick < 50) begin
            send_word(OP_PLACE, 8'($urandom), pick_coord(1'b0), pick_coord(1'b1),
                      $urandom, $urandom);
        end else if (pick < 66) begin
            send_word(OP_RECT, 8'($urandom), pick_coord(1'b0), pick_coord(1'b1),
                      pick_coord(1'b0), pick_coord(1'b1));
        end else if (pick < 82) begin
            idx = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, p * p - 1));
            send_word(OP_READ, idx, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 92) begin
            idx = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 14));
            v   = $urandom_range(0, 1) ? $urandom : even_split(idx % SPLIT_SLOTS);
            send_word($urandom_range(0, 1) ? OP_LOAD_Y : OP_LOAD_X, idx, v,
                      $urandom, $urandom, $urandom);
        end else if (pick < 96) begin
            send_word(OP_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_word($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, 8'($urandom),
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        logic [4:0] sizes [8];
        int idle_mix [3];
        sizes    = '{5'd16, 5'd2, 5'd0, 5'd31, 5'($urandom_range(3, 15)), 5'd1, 5'd17, 5'd4};
        idle_mix = '{0, 74, 12};
        for (int k = 0; k < 8; k++) begin
            set_grid_size(sizes[k]);
            for (int j = 0; j < 3; j++) begin
                sender_idle_pct = idle_mix[(k + j) % 3];
                repeat (17) random_command();
            end
        end
        sender_idle_pct = 0;
    endtask

    task automatic note_failure(input string what, input t_result want, input t_result got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected col %0d/%0d row %0d/%0d cell %0d slot %0d count %0d status %0d",
                     want.col_lo, want.col_hi, want.row_lo, want.row_hi, want.cell_id,
                     want.slot, want.count, want.status);
            $display("  actual   col %0d/%0d row %0d/%0d cell %0d slot %0d count %0d status %0d",
                     got.col_lo, got.col_hi, got.row_lo, got.row_hi, got.cell_id,
                     got.slot, got.count, got.status);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            seen_word = {o_col_lo, o_row_lo, o_col_hi, o_row_hi, o_cell_id,
                         o_slot, o_count, o_status};
            if (o_strobe !== 1'b1 || pending_results.size() == 0) begin
                note_failure("result word with none expected", '0, seen_word);
            end else begin
                due_word = pending_results.pop_front();
                n_checked++;
                if (seen_word.col_lo !== due_word.col_lo || seen_word.row_lo !== due_word.row_lo
                    || seen_word.col_hi !== due_word.col_hi
                    || seen_word.row_hi !== due_word.row_hi
                    || seen_word.cell_id !== due_word.cell_id
                    || seen_word.slot !== due_word.slot || seen_word.count !== due_word.count
                    || seen_word.status !== due_word.status) begin
                    note_failure("result word mismatch", due_word, seen_word);
                end
            end
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_op            = OP_LOAD_X;
        i_index         = '0;
        i_coord_x       = '0;
        i_coord_y       = '0;
        i_coord_x_hi    = '0;
        i_coord_y_hi    = '0;
        grid_size_reg   = 5'd4;
        sender_idle_pct = 0;
        n_sent          = 0;
        n_checked       = 0;
        n_mismatch      = 0;
        n_placed        = 0;
        n_rects         = 0;
        n_sizes         = 0;
        foreach (cell_tally[i]) cell_tally[i] = '0;
        foreach (x_bounds[i]) x_bounds[i] = '0;
        foreach (y_bounds[i]) y_bounds[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_split_tables();
        test_place_corners();
        test_count_reads();
        test_rectangles();
        test_clear_and_spare_ops();
        test_random_traffic();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) n_mismatch++;
        $display("Sent %0d commands over %0d grid sizes, including %0d placements and %0d rectangles.",
                 n_sent, n_sizes + 1, n_placed, n_rects);
        $display("Checked %0d result words, %0d failures.", n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
